>>> rtl/bdpt_pkg.sv
`timescale 1ns / 1ps

package bdpt_pkg;

  localparam int unsigned MsWidth    = 16;
  localparam int unsigned CountWidth = 17;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  localparam logic [CfgIdxWidth-1:0] CfgMinDownMs = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgMaxDownMs = 1'b1;

  localparam logic [MsWidth-1:0] MinDownMsReset = 16'd90;
  localparam logic [MsWidth-1:0] MaxDownMsReset = 16'd900;

  typedef struct packed {
    logic               is_down;
    logic               press_detected;
    logic [MsWidth-1:0] press_ms;
  } result_t;

endpackage

>>> rtl/bdpt_core.sv
`timescale 1ns / 1ps

module bdpt_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_fire_i,
  input  logic                              pin_level_i,
  input  logic [bdpt_pkg::MsWidth-1:0]      min_down_ms_i,
  input  logic [bdpt_pkg::MsWidth-1:0]      max_down_ms_i,
  output logic                              res_valid_o,
  output bdpt_pkg::result_t                 res_o
);

  logic                                previous_raw_q, previous_raw_d;
  logic                                debounced_q, debounced_d;
  logic [bdpt_pkg::CountWidth-1:0]     stable_count_q, stable_count_d;
  logic [bdpt_pkg::CountWidth-1:0]     held_count_q, held_count_d;
  logic                                press_done_q, press_done_d;

  logic [bdpt_pkg::CountWidth-1:0]     held_inc;
  logic [bdpt_pkg::CountWidth-1:0]     min_ext;
  logic [bdpt_pkg::CountWidth-1:0]     max_ext;
  logic                                change;
  logic                                in_window;

  assign min_ext = {1'b0, min_down_ms_i};
  assign max_ext = {1'b0, max_down_ms_i};

  assign held_inc = (held_count_q == bdpt_pkg::CountMax) ? held_count_q
                                                         : held_count_q + 1'b1;

  always_comb begin
    previous_raw_d = pin_level_i;
    if (pin_level_i != previous_raw_q) begin
      stable_count_d = '0;
    end else if (stable_count_q == bdpt_pkg::CountMax) begin
      stable_count_d = stable_count_q;
    end else begin
      stable_count_d = stable_count_q + 1'b1;
    end

    change    = (stable_count_d > min_ext) && (pin_level_i != debounced_q);
    in_window = (held_inc >= min_ext) && (held_inc <= max_ext) && !press_done_q;

    debounced_d          = debounced_q;
    held_count_d         = held_inc;
    press_done_d         = press_done_q;
    res_valid_o          = 1'b0;
    res_o.is_down        = 1'b0;
    res_o.press_detected = 1'b0;
    res_o.press_ms       = '0;

    if (change) begin
      res_valid_o = 1'b1;
      debounced_d = pin_level_i;
      if (!pin_level_i) begin
        held_count_d  = '0;
        press_done_d  = 1'b0;
        res_o.is_down = 1'b1;
      end else if (in_window) begin
        press_done_d         = 1'b1;
        res_o.press_detected = 1'b1;
        res_o.press_ms       = held_inc[bdpt_pkg::MsWidth-1:0];
      end
    end

    res_valid_o = res_valid_o && in_fire_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      previous_raw_q <= 1'b1;
      debounced_q    <= 1'b1;
      stable_count_q <= '0;
      held_count_q   <= '0;
      press_done_q   <= 1'b0;
    end else if (in_fire_i) begin
      previous_raw_q <= previous_raw_d;
      debounced_q    <= debounced_d;
      stable_count_q <= stable_count_d;
      held_count_q   <= held_count_d;
      press_done_q   <= press_done_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && res_valid_o && res_o.is_down |=> held_count_q == '0 && !press_done_q)
    else $error("press transaction did not restart the duration counter");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && res_valid_o && res_o.press_detected |=> press_done_q)
    else $error("reported press not marked handled");

endmodule

>>> rtl/button_debounce_press_timer.sv
`timescale 1ns / 1ps
// Each result is registered into the output register, or into the skid entry if that is held.
// One sample per cycle while skid is empty; counters and window compare finish in one pass.
// An output register plus one skid entry hold results; input stalls only when the skid is full.
// Reset: asynchronous active-low; hold time 90 ms, max press 900 ms, level released,
// counters and handled flag cleared, output empty.

module button_debounce_press_timer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bdpt_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [bdpt_pkg::MsWidth-1:0]          cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  pin_level_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  is_down_o,
  output logic                                  press_detected_o,
  output logic [bdpt_pkg::MsWidth-1:0]          press_ms_o
);

  logic [bdpt_pkg::MsWidth-1:0] min_down_ms_q;
  logic [bdpt_pkg::MsWidth-1:0] max_down_ms_q;

  logic              in_fire;
  logic              out_pop;
  logic              res_valid;
  bdpt_pkg::result_t res;

  logic              out_valid_q;
  bdpt_pkg::result_t out_q;
  logic              skid_valid_q;
  bdpt_pkg::result_t skid_q;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_pop    = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_down_ms_q <= bdpt_pkg::MinDownMsReset;
      max_down_ms_q <= bdpt_pkg::MaxDownMsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bdpt_pkg::CfgMinDownMs: min_down_ms_q <= cfg_wdata_i;
        bdpt_pkg::CfgMaxDownMs: max_down_ms_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bdpt_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .pin_level_i   (pin_level_i),
    .min_down_ms_i (min_down_ms_q),
    .max_down_ms_i (max_down_ms_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Drain skid first; otherwise load the fresh result into the free slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_down_o        = out_q.is_down;
  assign press_detected_o = out_q.press_detected;
  assign press_ms_o       = out_q.press_ms;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.press_detected |-> !out_q.is_down)
    else $error("press duration reported on a press transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.press_detected |-> out_q.press_ms == '0)
    else $error("nonzero duration without a detected press");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_pop |=> skid_valid_q && $stable(skid_q))
    else $error("skid entry lost while output stalled");

endmodule

>>> tb/debounce_event_monitor.sv
`timescale 1ns / 1ps

module debounce_event_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bdpt_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [bdpt_pkg::MsWidth-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             pin_level_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic                             is_down_i,
  input  logic                             press_detected_i,
  input  logic [bdpt_pkg::MsWidth-1:0]     press_ms_i,
  output int                               mismatches_o,
  output int                               pending_o
);

  logic [bdpt_pkg::MsWidth-1:0]    hold_ms;
  logic [bdpt_pkg::MsWidth-1:0]    max_ms;
  logic                            last_raw;
  logic                            deb_level;
  logic                            handled;
  logic [bdpt_pkg::CountWidth-1:0] stable_ticks;
  logic [bdpt_pkg::CountWidth-1:0] held_ticks;
  bdpt_pkg::result_t               expected_events[$];

  function automatic logic [bdpt_pkg::CountWidth-1:0] bump(
    input logic [bdpt_pkg::CountWidth-1:0] v
  );
    return (v == bdpt_pkg::CountMax) ? v : v + 1'b1;
  endfunction

  function automatic void debounce_tick(input logic level);
    bdpt_pkg::result_t ev;
    held_ticks = bump(held_ticks);
    stable_ticks = (level != last_raw) ? '0 : bump(stable_ticks);
    if (stable_ticks > hold_ms && level != deb_level) begin
      deb_level = level;
      ev = '0;
      if (!level) begin
        held_ticks = '0;
        handled = 1'b0;
        ev.is_down = 1'b1;
      end else if (held_ticks >= hold_ms && held_ticks <= max_ms && !handled) begin
        handled = 1'b1;
        ev.press_detected = 1'b1;
        ev.press_ms = held_ticks[bdpt_pkg::MsWidth-1:0];
      end
      expected_events.push_back(ev);
    end
    last_raw = level;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bdpt_pkg::result_t want;
    if (!rst_ni) begin
      hold_ms = bdpt_pkg::MinDownMsReset;
      max_ms = bdpt_pkg::MaxDownMsReset;
      last_raw = 1'b1;
      deb_level = 1'b1;
      handled = 1'b0;
      stable_ticks = '0;
      held_ticks = '0;
      expected_events.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: unexpected transaction is_down=%0b press_detected=%0b %s%0d",
                     $time, is_down_i, press_detected_i, "press_ms=", press_ms_i);
          mismatches_o++;
        end else begin
          want = expected_events.pop_front();
          if (want.is_down !== is_down_i || want.press_detected !== press_detected_i ||
              want.press_ms !== press_ms_i) begin
            if (mismatches_o < 10)
              $display("%0t: mismatch: expected is_down=%0b press_detected=%0b %s%0d, %s",
                       $time, want.is_down, want.press_detected, "press_ms=",
                       want.press_ms, "got",
                       " is_down=", is_down_i, " press_detected=", press_detected_i,
                       " press_ms=", press_ms_i);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == bdpt_pkg::CfgMinDownMs) hold_ms = cfg_wdata_i;
        else if (cfg_idx_i == bdpt_pkg::CfgMaxDownMs) max_ms = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) debounce_tick(pin_level_i);
      pending_o = expected_events.size();
    end
  end

endmodule

>>> tb/button_debounce_press_timer_tb.sv
`timescale 1ns / 1ps

module button_debounce_press_timer_tb;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [bdpt_pkg::CfgIdxWidth-1:0] cfg_idx = bdpt_pkg::CfgMinDownMs;
  logic [bdpt_pkg::MsWidth-1:0]     cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             pin_level = 1'b1;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             is_down;
  logic                             press_detected;
  logic [bdpt_pkg::MsWidth-1:0]     press_ms;
  int                               mismatches;
  int                               pending;
  bit                               quiet_in = 1'b0;
  bit                               quiet_out = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  button_debounce_press_timer i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .pin_level_i      (pin_level),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .is_down_o        (is_down),
    .press_detected_o (press_detected),
    .press_ms_o       (press_ms)
  );

  debounce_event_monitor i_monitor (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .pin_level_i      (pin_level),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .is_down_i        (is_down),
    .press_detected_i (press_detected),
    .press_ms_i       (press_ms),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  task automatic send_sample(input logic level);
    int unsigned gap;
    if (!quiet_in && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pin_level <= level;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_run(input logic level, input int unsigned count);
    repeat (count) send_sample(level);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(input logic [bdpt_pkg::MsWidth-1:0] lo,
                            input logic [bdpt_pkg::MsWidth-1:0] hi);
    cfg_we <= 1'b1;
    cfg_idx <= bdpt_pkg::CfgMinDownMs;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx <= bdpt_pkg::CfgMaxDownMs;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned lo, input int unsigned hi,
                              input int unsigned items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic        lvl;
    sent = 0;
    lvl = pin_level;
    set_window(lo[bdpt_pkg::MsWidth-1:0], hi[bdpt_pkg::MsWidth-1:0]);
    while (sent < items) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        lvl = 1'($urandom_range(0, 1));
        len = 1;
      end else begin
        lvl = ~lvl;
        if (pick == 1) len = $urandom_range(1, lo + 1);
        else len = $urandom_range(lo + 2, lo + 24);
      end
      send_run(lvl, len);
      sent += len;
    end
    drain();
  endtask

  initial begin : stall_gen
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (!quiet_out && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    int unsigned lo;
    int unsigned hi;
    int unsigned spin;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_run(1'b1, 3);
    send_run(1'b0, 150 + $urandom_range(0, 100));
    send_run(1'b1, 95 + $urandom_range(0, 20));
    drain();

    set_window(16'd2, 16'd5);
    send_run(1'b0, 5);
    send_run(1'b1, 4);
    send_run(1'b0, 6);
    send_run(1'b1, 4);
    drain();
    set_window(16'd0, 16'd0);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    drain();
    set_window(16'd0, 16'hFFFF);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: begin
          lo = $urandom_range(0, 3);
          hi = $urandom_range(lo, lo + 30);
        end
        1: begin
          lo = $urandom_range(4, 12);
          hi = $urandom_range(lo + 5, lo + 40);
        end
        2: begin
          lo = $urandom_range(0, 8);
          hi = 16'hFFFF;
        end
        3: begin
          lo = $urandom_range(5, 12);
          hi = $urandom_range(0, lo - 1);
        end
        default: begin
          lo = $urandom_range(1, 6);
          hi = 0;
        end
      endcase
      random_phase(lo, hi, 80);
    end

    quiet_in = 1'b1;
    quiet_out = 1'b1;
    random_phase(2, 40, 100);

    spin = 0;
    @(negedge clk);
    while (pending != 0 && spin < 1000) begin
      @(negedge clk);
      spin++;
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** button_debounce_press_timer: PASSED **");
    end else begin
      $display("** button_debounce_press_timer: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("** button_debounce_press_timer: FAILED **");
    $finish;
  end

endmodule

>>> files.f
rtl/bdpt_pkg.sv
rtl/bdpt_core.sv
rtl/button_debounce_press_timer.sv
tb/debounce_event_monitor.sv
tb/button_debounce_press_timer_tb.sv
